// File: hw/rtl/mup_pkg.sv
// Package: shared constants for the USB-MIDI event packer.
`default_nettype none

package mup_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned NIB_W   = 4;
  localparam int unsigned CNT_W   = 2;
  localparam int unsigned HOLD_N  = 3;

  // status bytes
  localparam logic [BYTE_W-1:0] SB_SYSEX_START = 8'hF0;
  localparam logic [BYTE_W-1:0] SB_SYSEX_END   = 8'hF7;
  localparam logic [BYTE_W-1:0] SB_COMMON_LO   = 8'hF4;
  localparam logic [BYTE_W-1:0] SB_COMMON_HI   = 8'hF6;
  localparam logic [BYTE_W-1:0] SB_REALTIME_LO = 8'hF8;

  // status high nibbles
  localparam logic [NIB_W-1:0] HI_SYSTEM  = 4'hF;
  localparam logic [NIB_W-1:0] HI_PROG    = 4'hC;
  localparam logic [NIB_W-1:0] HI_CHPRESS = 4'hD;
  localparam logic [NIB_W-1:0] HI_VOICE   = 4'h8;

  // system common low nibbles
  localparam logic [NIB_W-1:0] LO_MTC     = 4'h1;
  localparam logic [NIB_W-1:0] LO_SONGPOS = 4'h2;
  localparam logic [NIB_W-1:0] LO_SONGSEL = 4'h3;

  // code index numbers
  localparam logic [NIB_W-1:0] CIN_COMMON_2 = 4'h2;
  localparam logic [NIB_W-1:0] CIN_COMMON_3 = 4'h3;
  localparam logic [NIB_W-1:0] CIN_SYSEX    = 4'h4;
  localparam logic [NIB_W-1:0] CIN_SINGLE   = 4'h5;
  localparam logic [NIB_W-1:0] CIN_SYSEX_E2 = 4'h6;
  localparam logic [NIB_W-1:0] CIN_SYSEX_E3 = 4'h7;
  localparam logic [NIB_W-1:0] CIN_REALTIME = 4'hF;

endpackage

`default_nettype wire

// File: hw/rtl/midi_byte_to_usb_event_packer_core.sv
// Top level: serial MIDI byte to USB-MIDI event packet packer.
//
// Input channel: one MIDI byte per beat on in_midi_byte, in_valid/in_stall.
// Output channel: one event packet per beat (cable, code index, three
// payload bytes), out_valid/out_stall. Bytes that complete no message
// (status bytes, partial messages, stray data) give no output beat.
// Config channel: cfg_valid/cfg_ready with cfg_cable_number; always ready.
// Write it only while the block is idle.
//
// Datapath: an accepted byte is held in the stage register; when the output
// register is free it is processed and its packet is registered there.
// Throughput: one byte per cycle while the receiver does not stall; the
// running status, count and held bytes are updated from the staged byte as
// it is processed, and the loop through that state sets the rate.
//
// Reset (rst_n low, synchronous) clears running status, count, sysex flag,
// cable number and both stage valids. When the receiver stalls, the output
// register holds its packet and the staged byte waits, so in_stall rises
// only while both the stage and the output register are occupied.
`default_nettype none

module midi_byte_to_usb_event_packer_core (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_midi_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [3:0]      out_cable_out,
  output logic [3:0]      out_code_index,
  output logic [7:0]      out_payload_0,
  output logic [7:0]      out_payload_1,
  output logic [7:0]      out_payload_2,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [3:0] cfg_cable_number
);

  logic [7:0] byte_r;
  logic       stg_valid_r;
  logic [3:0] cable_r;
  logic [7:0] rs_r, rs_nxt;
  logic [1:0] count_r, count_nxt;
  logic       sysex_r, sysex_nxt;
  logic [7:0] held_r   [mup_pkg::HOLD_N];
  logic [7:0] held_nxt [mup_pkg::HOLD_N];

  logic       out_valid_r;
  logic [3:0] cin_r;
  logic [7:0] p0_r, p1_r, p2_r;

  logic       emit;
  logic [3:0] cin_nxt;
  logic [7:0] p0_nxt, p1_nxt, p2_nxt;
  logic [1:0] cnt_inc;
  logic [1:0] eox_pos;
  logic [3:0] hi;
  logic [3:0] lo;

  logic out_free;
  logic proc;
  logic in_take;

  assign out_free = !out_valid_r || !out_stall;
  assign proc     = stg_valid_r && out_free;
  assign in_stall = stg_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  assign hi      = rs_r[7:4];
  assign lo      = rs_r[3:0];
  assign cnt_inc = count_r + 2'd1;
  assign eox_pos = (count_r > 2'd2) ? 2'd2 : count_r;

  always_comb begin
    rs_nxt    = rs_r;
    count_nxt = count_r;
    sysex_nxt = sysex_r;
    for (int i = 0; i < mup_pkg::HOLD_N; i++) begin
      held_nxt[i] = held_r[i];
    end
    emit    = 1'b0;
    cin_nxt = mup_pkg::CIN_REALTIME;
    p0_nxt  = byte_r;
    p1_nxt  = 8'h00;
    p2_nxt  = 8'h00;

    if (byte_r[7]) begin
      priority if (byte_r >= mup_pkg::SB_REALTIME_LO) begin
        emit = 1'b1;
      end else if (byte_r >= mup_pkg::SB_COMMON_LO && byte_r <= mup_pkg::SB_COMMON_HI) begin
        count_nxt = 2'd0;
        emit      = 1'b1;
        cin_nxt   = mup_pkg::CIN_SINGLE;
      end else if (byte_r == mup_pkg::SB_SYSEX_START) begin
        sysex_nxt   = 1'b1;
        held_nxt[0] = byte_r;
        count_nxt   = 2'd1;
      end else if (byte_r == mup_pkg::SB_SYSEX_END) begin
        for (int i = 0; i < mup_pkg::HOLD_N; i++) begin
          if (eox_pos == 2'(i)) held_nxt[i] = byte_r;
        end
        emit      = 1'b1;
        sysex_nxt = 1'b0;
        count_nxt = 2'd0;
        p0_nxt    = held_nxt[0];
        unique case (eox_pos)
          2'd0: cin_nxt = mup_pkg::CIN_SINGLE;
          2'd1: begin
            cin_nxt = mup_pkg::CIN_SYSEX_E2;
            p1_nxt  = held_nxt[1];
          end
          default: begin
            cin_nxt = mup_pkg::CIN_SYSEX_E3;
            p1_nxt  = held_nxt[1];
            p2_nxt  = held_nxt[2];
          end
        endcase
      end else begin
        rs_nxt    = byte_r;
        count_nxt = 2'd0;
      end
    end else begin
      for (int i = 0; i < mup_pkg::HOLD_N; i++) begin
        if (count_r == 2'(i)) held_nxt[i] = byte_r;
      end
      count_nxt = cnt_inc;
      if (sysex_r) begin
        if (cnt_inc == 2'd3) begin
          count_nxt = 2'd0;
          emit      = 1'b1;
          cin_nxt   = mup_pkg::CIN_SYSEX;
          p0_nxt    = held_nxt[0];
          p1_nxt    = held_nxt[1];
          p2_nxt    = held_nxt[2];
        end
      end else begin
        p0_nxt = rs_r;
        p1_nxt = held_nxt[0];
        priority if (hi == mup_pkg::HI_SYSTEM) begin
          if (lo == mup_pkg::LO_MTC || lo == mup_pkg::LO_SONGSEL) begin
            count_nxt = 2'd0;
            emit      = 1'b1;
            cin_nxt   = mup_pkg::CIN_COMMON_2;
          end else if (lo == mup_pkg::LO_SONGPOS && cnt_inc == 2'd2) begin
            count_nxt = 2'd0;
            emit      = 1'b1;
            cin_nxt   = mup_pkg::CIN_COMMON_3;
            p2_nxt    = held_nxt[1];
          end
        end else if (hi == mup_pkg::HI_PROG || hi == mup_pkg::HI_CHPRESS) begin
          if (cnt_inc == 2'd1) begin
            count_nxt = 2'd0;
            emit      = 1'b1;
            cin_nxt   = hi;
          end
        end else if (hi >= mup_pkg::HI_VOICE) begin
          if (cnt_inc == 2'd2) begin
            count_nxt = 2'd0;
            emit      = 1'b1;
            cin_nxt   = hi;
            p2_nxt    = held_nxt[1];
          end
        end else begin
          count_nxt = 2'd0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      cable_r     <= 4'h0;
      rs_r        <= 8'h00;
      count_r     <= 2'd0;
      sysex_r     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) cable_r <= cfg_cable_number;
      if (in_take) begin
        stg_valid_r <= 1'b1;
      end else if (proc) begin
        stg_valid_r <= 1'b0;
      end
      if (proc) begin
        out_valid_r <= emit;
        rs_r        <= rs_nxt;
        count_r     <= count_nxt;
        sysex_r     <= sysex_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) byte_r <= in_midi_byte;
    if (proc) begin
      for (int i = 0; i < mup_pkg::HOLD_N; i++) begin
        held_r[i] <= held_nxt[i];
      end
    end
    if (proc && emit) begin
      cin_r <= cin_nxt;
      p0_r  <= p0_nxt;
      p1_r  <= p1_nxt;
      p2_r  <= p2_nxt;
    end
  end

  logic [3:0] cable_out_r;
  always_ff @(posedge clk) begin
    if (proc && emit) cable_out_r <= cable_r;
  end

  assign out_valid      = out_valid_r;
  assign out_cable_out  = cable_out_r;
  assign out_code_index = cin_r;
  assign out_payload_0  = p0_r;
  assign out_payload_1  = p1_r;
  assign out_payload_2  = p2_r;

endmodule

`default_nettype wire

// File: hw/rtl/mup_checker.sv
// Checker: port-level properties of the event packer, with its bind.
`default_nettype none

module mup_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [3:0] out_code_index,
  input wire logic [7:0] out_payload_0,
  input wire logic [7:0] out_payload_1,
  input wire logic [7:0] out_payload_2
);

  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output beat valid after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_code_index) &&
      $stable(out_payload_0) && $stable(out_payload_1) && $stable(out_payload_2))
    else $error("stalled beat changed");

  a_no_reserved_cin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_code_index != 4'h0 && out_code_index != 4'h1)
    else $error("reserved code index emitted");

  a_realtime_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_code_index == mup_pkg::CIN_REALTIME |->
      out_payload_0 >= mup_pkg::SB_REALTIME_LO && out_payload_1 == 8'h00 &&
      out_payload_2 == 8'h00)
    else $error("malformed real-time packet");

  a_voice_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_code_index >= mup_pkg::HI_VOICE &&
      out_code_index != mup_pkg::CIN_REALTIME |->
      out_payload_0[7:4] == out_code_index)
    else $error("voice packet status does not match code index");

endmodule

bind midi_byte_to_usb_event_packer_core mup_checker u_mup_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_code_index (out_code_index),
  .out_payload_0  (out_payload_0),
  .out_payload_1  (out_payload_1),
  .out_payload_2  (out_payload_2)
);

`default_nettype wire
